// ===== hdl/upc_pkg.sv =====
// ----------------------------------------------------------------------------
// upc_pkg
// Shared types, character constants and byte helpers for the URL percent
// encoder/decoder.
// ----------------------------------------------------------------------------
package upc_pkg;

  // Characters used by the codec
  localparam logic [7:0] CHR_PCT   = 8'h25;  // '%'
  localparam logic [7:0] CHR_PLUS  = 8'h2B;  // '+'
  localparam logic [7:0] CHR_SPACE = 8'h20;  // ' '
  localparam logic [7:0] CHR_TILDE = 8'h7E;  // '~'
  localparam logic [7:0] CHR_DASH  = 8'h2D;  // '-'
  localparam logic [7:0] CHR_DOT   = 8'h2E;  // '.'
  localparam logic [7:0] CHR_USCR  = 8'h5F;  // '_'
  localparam logic [3:0] NIBBLE_MASK = 4'hF;

  // Codec mode register values
  localparam logic MODE_DECODE = 1'b0;
  localparam logic MODE_ENCODE = 1'b1;

  // Uppercase hex digit table, indexed by nibble
  localparam logic [15:0][7:0] HEX_DIGITS = {
    8'h46, 8'h45, 8'h44, 8'h43, 8'h42, 8'h41, 8'h39, 8'h38,
    8'h37, 8'h36, 8'h35, 8'h34, 8'h33, 8'h32, 8'h31, 8'h30
  };

  // Decoder hold state: nothing, a '%', or a '%' plus one hex digit
  typedef enum logic [2:0] {
    HOLD_NONE  = 3'b001,
    HOLD_PCT   = 3'b010,
    HOLD_DIGIT = 3'b100
  } hold_e;

  // One queued word group: up to three result bytes from one input word
  typedef struct packed {
    logic [2:0][7:0] data;
    logic [1:0]      num;   // 1..3 bytes valid
    logic            last;  // input word closed the string
  } upc_entry_t;

  // Front to queue push request
  typedef struct packed {
    logic       valid;
    upc_entry_t entry;
  } upc_push_t;

  function automatic logic is_hex(input logic [7:0] b);
    return ((b >= 8'h30) && (b <= 8'h39)) ||
           ((b >= 8'h41) && (b <= 8'h46)) ||
           ((b >= 8'h61) && (b <= 8'h66));
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] b);
    logic [7:0] v;
    v = 8'h00;
    if ((b >= 8'h30) && (b <= 8'h39)) begin
      v = b - 8'h30;
    end else if ((b >= 8'h41) && (b <= 8'h46)) begin
      v = b - 8'h37;
    end else if ((b >= 8'h61) && (b <= 8'h66)) begin
      v = b - 8'h57;
    end
    return v[3:0];
  endfunction

  function automatic logic is_plain(input logic [7:0] b);
    return ((b >= 8'h41) && (b <= 8'h5A)) ||
           ((b >= 8'h61) && (b <= 8'h7A)) ||
           ((b >= 8'h30) && (b <= 8'h39)) ||
           (b == CHR_DASH) || (b == CHR_DOT) || (b == CHR_USCR) || (b == CHR_TILDE);
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    return HEX_DIGITS[nib & NIBBLE_MASK];
  endfunction

endpackage

// ===== hdl/upc_front.sv =====
// ----------------------------------------------------------------------------
// upc_front
// Accepts input words, holds the mode register and decoder escape state, and
// turns each word into a group of zero to three result bytes for the queue.
// ----------------------------------------------------------------------------
module upc_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              codec_mode_we_i,
  input  logic              codec_mode_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        in_byte_i,
  input  logic              in_last_i,
  input  logic              q_full_i,
  output upc_pkg::upc_push_t push_o
);
  import upc_pkg::*;

  logic       mode_q;
  hold_e      hold_q, hold_d;
  logic [7:0] held_q, held_d;
  logic       accept;
  upc_entry_t ent;

  // plain-byte decode with nothing held
  logic       pl_hold;
  logic       pl_emit;
  logic [7:0] pl_byte;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  assign pl_hold = (in_byte_i == CHR_PCT) && !in_last_i;
  assign pl_emit = !pl_hold;
  assign pl_byte = (in_byte_i == CHR_PLUS) ? CHR_SPACE : in_byte_i;

  // classify the word and build its result group
  always_comb begin
    ent       = '0;
    ent.last  = in_last_i;
    hold_d    = hold_q;
    held_d    = held_q;
    if (mode_q == MODE_ENCODE) begin
      hold_d = HOLD_NONE;
      if (is_plain(in_byte_i)) begin
        ent.data[0] = in_byte_i;
        ent.num     = 2'd1;
      end else begin
        ent.data[0] = CHR_PCT;
        ent.data[1] = hex_char(in_byte_i[7:4]);
        ent.data[2] = hex_char(in_byte_i[3:0]);
        ent.num     = 2'd3;
      end
    end else begin
      unique case (hold_q)
        HOLD_DIGIT: begin
          if (is_hex(in_byte_i)) begin
            ent.data[0] = {hex_val(held_q), hex_val(in_byte_i)};
            ent.num     = 2'd1;
            hold_d      = HOLD_NONE;
          end else begin
            // bad second digit: flush '%' and digit, redo this byte
            ent.data[0] = CHR_PCT;
            ent.data[1] = held_q;
            ent.data[2] = pl_byte;
            ent.num     = pl_emit ? 2'd3 : 2'd2;
            hold_d      = pl_hold ? HOLD_PCT : HOLD_NONE;
          end
        end
        HOLD_PCT: begin
          if (is_hex(in_byte_i)) begin
            if (in_last_i) begin
              // short escape at string end
              ent.data[0] = CHR_PCT;
              ent.data[1] = in_byte_i;
              ent.num     = 2'd2;
              hold_d      = HOLD_NONE;
            end else begin
              held_d = in_byte_i;
              hold_d = HOLD_DIGIT;
            end
          end else begin
            // bad first digit: flush '%', redo this byte
            ent.data[0] = CHR_PCT;
            ent.data[1] = pl_byte;
            ent.num     = pl_emit ? 2'd2 : 2'd1;
            hold_d      = pl_hold ? HOLD_PCT : HOLD_NONE;
          end
        end
        default: begin
          // nothing held
          ent.data[0] = pl_byte;
          ent.num     = pl_emit ? 2'd1 : 2'd0;
          hold_d      = pl_hold ? HOLD_PCT : HOLD_NONE;
        end
      endcase
    end
  end

  assign push_o.valid = accept && (ent.num != 2'd0);
  assign push_o.entry = ent;

  // mode register and escape state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_DECODE;
      hold_q <= HOLD_NONE;
    end else if (codec_mode_we_i) begin
      mode_q <= codec_mode_i;
      hold_q <= HOLD_NONE;
    end else if (accept) begin
      hold_q <= hold_d;
    end
  end

  // held hex digit, only read while a digit is held
  always_ff @(posedge clk_i) begin
    if (accept) begin
      held_q <= held_d;
    end
  end

endmodule

// ===== hdl/upc_queue.sv =====
// ----------------------------------------------------------------------------
// upc_queue
// Short FIFO of result groups between the front and the back.
// ----------------------------------------------------------------------------
module upc_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  upc_pkg::upc_push_t push_i,
  input  logic               pop_i,
  output logic               full_o,
  output logic               head_valid_o,
  output upc_pkg::upc_entry_t head_o
);
  import upc_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  upc_entry_t     slot_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o       = (cnt_q == FullCnt);
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = slot_q[rd_ptr_q];
  assign do_push      = push_i.valid && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_i.entry;
    end
  end

endmodule

// ===== hdl/upc_back.sv =====
// ----------------------------------------------------------------------------
// upc_back
// Walks the head group of the queue one byte at a time into the output
// register, marking the last byte of each group and of the string.
// ----------------------------------------------------------------------------
module upc_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                head_valid_i,
  input  upc_pkg::upc_entry_t head_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [7:0]          out_byte_o,
  output logic                run_last_o,
  output logic                string_end_o
);
  import upc_pkg::*;

  logic [1:0] idx_q;
  logic       out_valid_q;
  logic [7:0] out_byte_q;
  logic       run_last_q, string_end_q;
  logic       load;
  logic       fin;

  // output register is free when empty or being drained
  assign load = head_valid_i && (!out_valid_q || out_ready_i);
  assign fin  = (idx_q == (head_i.num - 2'd1));
  assign pop_o = load && fin;

  // control: valid flag and byte index within the group
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        idx_q       <= fin ? 2'd0 : idx_q + 2'd1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_byte_q   <= head_i.data[idx_q];
      run_last_q   <= fin;
      string_end_q <= fin && head_i.last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_byte_o   = out_byte_q;
  assign run_last_o   = run_last_q;
  assign string_end_o = string_end_q;

endmodule

// ===== hdl/url_percent_codec.sv =====
// ----------------------------------------------------------------------------
// url_percent_codec
// Streaming URL percent encoder/decoder, one input byte per word.
// ----------------------------------------------------------------------------
//   channel  | direction | handshake              | payload
//   ---------+-----------+------------------------+------------------------------
//   in       | input     | in_valid_i/in_ready_o  | in_byte_i, in_last_i
//   out      | output    | out_valid_o/out_ready_i| out_byte_o, run_last_o,
//            |           |                        | string_end_o
//   mode     | input     | codec_mode_we_i        | codec_mode_i
//
// One input word per cycle is taken while the queue has room; the output
// register gives one byte per cycle while out_ready_i is high, so a word
// that yields one byte sustains one per cycle and an encoded escape holds
// the output for its three bytes. A result is registered in the queue, then in
// the output register. The queue holds QUEUE_DEPTH result groups; a stalled
// output fills it and then drops in_ready_o. Reset (asynchronous, active low)
// selects decode mode with nothing held; a mode write also drops any held escape.
// ----------------------------------------------------------------------------
module url_percent_codec #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       codec_mode_we_i,
  input  logic       codec_mode_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       run_last_o,
  output logic       string_end_o
);
  import upc_pkg::*;

  upc_push_t  push;
  upc_entry_t head;
  logic       q_full, head_valid, pop;

  // front: accept and classify
  upc_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .codec_mode_we_i (codec_mode_we_i),
    .codec_mode_i    (codec_mode_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .in_byte_i       (in_byte_i),
    .in_last_i       (in_last_i),
    .q_full_i        (q_full),
    .push_o          (push)
  );

  // queue of result groups
  upc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .pop_i        (pop),
    .full_o       (q_full),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  // back: serialize bytes to the output register
  upc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_byte_o   (out_byte_o),
    .run_last_o   (run_last_o),
    .string_end_o (string_end_o)
  );

endmodule

// ===== hdl/upc_checker.sv =====
// ----------------------------------------------------------------------------
// upc_checker
// Port-level checks for the URL percent codec, bound to the top level.
// ----------------------------------------------------------------------------
module upc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic [7:0] in_byte_i,
  input logic       in_last_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] out_byte_o,
  input logic       run_last_o,
  input logic       string_end_o
);

  // a stalled input word stays offered with the same payload
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=>
      in_valid_i && $stable(in_byte_i) && $stable(in_last_i))
    else $error("input word changed while stalled");

  // a stalled output word stays valid
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output word dropped while stalled");

  // a stalled output word keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      $stable(out_byte_o) && $stable(run_last_o) && $stable(string_end_o))
    else $error("output payload changed while stalled");

  // string end only on the closing byte of a group
  a_end_on_run_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && string_end_o |-> run_last_o)
    else $error("string end flagged mid group");

  // the rest of a group follows without a gap
  a_group_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !run_last_o |=> out_valid_o)
    else $error("gap inside a result group");

endmodule

bind url_percent_codec upc_checker u_upc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .in_byte_i    (in_byte_i),
  .in_last_i    (in_last_i),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .out_byte_o   (out_byte_o),
  .run_last_o   (run_last_o),
  .string_end_o (string_end_o)
);
